/* rtl/chfm_pkg.sv */
// Shared types and constants for the compass heading block.
// No dependencies; imported by chfm_cordic and the top level.
package chfm_pkg;

  localparam int SAMPLE_BITS_DEF       = 16;
  localparam int ANGLE_FRAC_BITS_DEF   = 7;
  localparam int CORDIC_ITERATIONS_DEF = 16;

  // vector components carry 30 fraction bits, angles are degrees * 2^20
  localparam int VEC_FRAC = 30;
  localparam int INT_FRAC = 20;
  localparam int ACC_W    = 30;
  localparam int H_W      = 29;
  localparam int ATAN_W   = 26;
  localparam int ATAN_N   = 24;

  localparam logic signed [ACC_W-1:0] DEG90  = ACC_W'(90 <<< INT_FRAC);
  localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(180 <<< INT_FRAC);
  localparam logic [H_W-1:0]          DEG360 = H_W'(360 <<< INT_FRAC);

  // atan(2^-i) in degrees * 2^20
  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_N] = '{
    26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121,
    26'd3750058,  26'd1876857,  26'd938658,   26'd469357,
    26'd234682,   26'd117342,   26'd58671,    26'd29335,
    26'd14668,    26'd7334,     26'd3667,     26'd1833,
    26'd917,      26'd458,      26'd229,      26'd115,
    26'd57,       26'd29,       26'd14,       26'd7
  };

  localparam int HEAD_W = 16;
  localparam int REG_W  = 16;
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  localparam logic [1:0] REG_OFFSET_X   = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y   = 2'd1;
  localparam logic [1:0] REG_AXIS_ANGLE = 2'd2;

  localparam logic [REG_W-1:0] AXIS_ANGLE_RESET = 16'd25600;

  // offset mod full circle: reciprocal multiply, 2^-32 scaled
  localparam int RECIP_SH = 32;
  localparam int RECIP_W  = 24;
  localparam int OFF_Q_W  = 8;

  typedef struct packed {
    logic zero;
    logic x_pos;
  } chfm_side_t;

endpackage

/* rtl/chfm_cordic.sv */
// Pipelined CORDIC vectoring unit, one micro-rotation per register stage.
// Depends on chfm_pkg (angle table, widths, sideband type).
module chfm_cordic #(
  parameter int SAMPLE_BITS       = chfm_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_ITERATIONS = chfm_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              en,
  input  logic                                              in_valid,
  input  logic signed [SAMPLE_BITS+3+chfm_pkg::VEC_FRAC-1:0] p_in,
  input  logic signed [SAMPLE_BITS+3+chfm_pkg::VEC_FRAC-1:0] q_in,
  input  logic signed [chfm_pkg::ACC_W-1:0]                 acc_in,
  input  chfm_pkg::chfm_side_t                              side_in,
  output logic                                              out_valid,
  output logic signed [chfm_pkg::ACC_W-1:0]                 acc_out,
  output chfm_pkg::chfm_side_t                              side_out
);
  import chfm_pkg::*;

  localparam int W = SAMPLE_BITS + 3 + VEC_FRAC;
  localparam int N = CORDIC_ITERATIONS;

  logic signed [W-1:0]     p_c   [N];
  logic signed [W-1:0]     q_c   [N];
  logic signed [ACC_W-1:0] acc_c [N];
  logic                    v_c   [N];
  chfm_side_t              sd_c  [N];

  logic signed [W-1:0]     p_r   [N-1];
  logic signed [W-1:0]     q_r   [N-1];
  logic signed [ACC_W-1:0] acc_r [N];
  logic                    v_r   [N];
  chfm_side_t              sd_r  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [ACC_W-1:0] ang;
    logic signed [ACC_W-1:0] acc_next;

    if (i == 0) begin : g_first
      assign p_c[i]   = p_in;
      assign q_c[i]   = q_in;
      assign acc_c[i] = acc_in;
      assign v_c[i]   = in_valid;
      assign sd_c[i]  = side_in;
    end else begin : g_rest
      assign p_c[i]   = p_r[i-1];
      assign q_c[i]   = q_r[i-1];
      assign acc_c[i] = acc_r[i-1];
      assign v_c[i]   = v_r[i-1];
      assign sd_c[i]  = sd_r[i-1];
    end

    assign ang = $signed(ACC_W'(ATAN_TAB[i]));

    always_comb begin
      if (!q_c[i][W-1]) begin
        acc_next = acc_c[i] + ang;
      end else begin
        acc_next = acc_c[i] - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_c[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[i] <= acc_next;
        sd_r[i]  <= sd_c[i];
      end
    end

    // the last stage only needs the sign of q
    if (i < N - 1) begin : g_vec
      logic signed [W-1:0] dp;
      logic signed [W-1:0] dq;
      logic signed [W-1:0] p_next;
      logic signed [W-1:0] q_next;

      // arithmetic shift is a floor shift
      assign dp = q_c[i] >>> i;
      assign dq = p_c[i] >>> i;

      always_comb begin
        if (!q_c[i][W-1]) begin
          p_next = p_c[i] + dp;
          q_next = q_c[i] - dq;
        end else begin
          p_next = p_c[i] - dp;
          q_next = q_c[i] + dq;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          p_r[i] <= p_next;
          q_r[i] <= q_next;
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign acc_out   = acc_r[N-1];
  assign side_out  = sd_r[N-1];

endmodule

/* rtl/compass_heading_from_magnetometer_top.sv */
// Top level of the compass heading block: APB registers, offset correction,
// heading post-processing and output register. Depends on chfm_pkg, chfm_cordic.

// Takes one magnetometer word (mag_x, mag_y) per clock while the pipeline is
// not held, and returns one heading word per input, in order, through one
// pipeline stage per CORDIC micro-rotation, plus input correction, quadrant
// pre-rotation, clamp, rounding and the output register. Throughput is one
// word per cycle; when the output word is not taken the whole pipeline holds.
// Headings are degrees * 2^ANGLE_FRAC_BITS. A change of axis_angle reaches
// the reduced offset used at the output through the off_prod, off_r and
// off_red registers.
module compass_heading_from_magnetometer_top #(
  parameter int SAMPLE_BITS       = chfm_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_FRAC_BITS   = chfm_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_ITERATIONS = chfm_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // APB register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [chfm_pkg::APB_AW-1:0]           paddr,
  input  logic [chfm_pkg::APB_DW-1:0]           pwdata,
  output logic [chfm_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready,
  // sample stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // mag_x, mag_y, zero fill
  // heading stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [2*chfm_pkg::HEAD_W-1:0]         m_tdata,  // heading_north, heading_axis
  output logic                                  m_tuser   // zero_field
);
  import chfm_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int W      = SB + 3 + VEC_FRAC;
  localparam int FULL   = 360 << ANGLE_FRAC_BITS;
  localparam int ANG_W  = $clog2(2 * FULL);
  localparam int RND_SH = INT_FRAC - ANGLE_FRAC_BITS;
  localparam int PQ_W   = ANG_W + OFF_Q_W;
  localparam logic [ANG_W-1:0]   FULL_A  = ANG_W'(FULL);
  localparam logic [H_W:0]       RND_HALF = (H_W+1)'(1) << (RND_SH - 1);
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SH) / FULL);

  // ---------------- registers ----------------
  logic [REG_W-1:0] offset_x;
  logic [REG_W-1:0] offset_y;
  logic [REG_W-1:0] axis_angle;
  logic             wr_en;
  logic [1:0]       wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x   <= '0;
      offset_y   <= '0;
      axis_angle <= AXIS_ANGLE_RESET;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_OFFSET_X:   offset_x   <= pwdata[REG_W-1:0];
        REG_OFFSET_Y:   offset_y   <= pwdata[REG_W-1:0];
        REG_AXIS_ANGLE: axis_angle <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_OFFSET_X:   prdata = APB_DW'(offset_x);
      REG_OFFSET_Y:   prdata = APB_DW'(offset_y);
      REG_AXIS_ANGLE: prdata = APB_DW'(axis_angle);
      default:        prdata = '0;
    endcase
  end

  // axis offset mod 360: reciprocal estimate is low by at most one
  logic [REG_W+RECIP_W-1:0] off_prod;
  logic [REG_W-1:0]         off_d1;
  logic [OFF_Q_W-1:0]       off_q;
  logic [PQ_W-1:0]          off_qf;
  logic [PQ_W-1:0]          off_diff;
  logic [ANG_W-1:0]         off_r;
  logic [ANG_W-1:0]         off_red;

  assign off_q    = off_prod[RECIP_SH +: OFF_Q_W];
  assign off_qf   = PQ_W'(off_q) * PQ_W'(FULL);
  assign off_diff = PQ_W'(off_d1) - off_qf;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_prod <= '0;
      off_d1   <= '0;
      off_r    <= '0;
      off_red  <= '0;
    end else begin
      off_prod <= (REG_W+RECIP_W)'(axis_angle) * (REG_W+RECIP_W)'(RECIP_M);
      off_d1   <= axis_angle;
      off_r    <= off_diff[ANG_W-1:0];
      off_red  <= (off_r >= FULL_A) ? off_r - FULL_A : off_r;
    end
  end

  // ---------------- pipeline ----------------
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 0: hard-iron correction
  logic [SB-1:0]        ox_s;
  logic [SB-1:0]        oy_s;
  logic [SB-1:0]        mag_x;
  logic [SB-1:0]        mag_y;
  logic                 v0;
  logic signed [SB:0]   cx0;
  logic signed [SB:0]   cy0;

  assign ox_s  = SB'(offset_x);
  assign oy_s  = SB'(offset_y);
  assign mag_x = s_tdata[SB-1:0];
  assign mag_y = s_tdata[2*SB-1:SB];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx0 <= $signed({mag_x[SB-1], mag_x}) - $signed({ox_s[SB-1], ox_s});
      cy0 <= $signed({mag_y[SB-1], mag_y}) - $signed({oy_s[SB-1], oy_s});
    end
  end

  // stage 1: fold to q >= 0, rotate a lower half-plane vector by -90
  logic signed [SB:0]      cx_abs;
  logic signed [W-1:0]     cx_w;
  logic signed [W-1:0]     cy_w;
  logic signed [W-1:0]     p_next;
  logic signed [W-1:0]     q_next;
  logic signed [ACC_W-1:0] acc_next;
  chfm_side_t              side_next;

  logic                    v1;
  logic signed [W-1:0]     p1;
  logic signed [W-1:0]     q1;
  logic signed [ACC_W-1:0] acc1;
  chfm_side_t              side1;

  assign cx_abs = cx0[SB] ? -cx0 : cx0;
  assign cx_w   = W'(cx_abs) <<< VEC_FRAC;
  assign cy_w   = W'(cy0) <<< VEC_FRAC;

  always_comb begin
    side_next.zero  = (cx0 == '0) && (cy0 == '0);
    side_next.x_pos = !cx0[SB] && (cx0 != '0);
    if (cy0[SB]) begin
      p_next   = cx_w;
      q_next   = -cy_w;
      acc_next = DEG90;
    end else begin
      p_next   = cy_w;
      q_next   = cx_w;
      acc_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= p_next;
      q1    <= q_next;
      acc1  <= acc_next;
      side1 <= side_next;
    end
  end

  logic                    vc;
  logic signed [ACC_W-1:0] acc_c;
  chfm_side_t              side_c;

  chfm_cordic #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .p_in      (p1),
    .q_in      (q1),
    .acc_in    (acc1),
    .side_in   (side1),
    .out_valid (vc),
    .acc_out   (acc_c),
    .side_out  (side_c)
  );

  // stage A: clamp to 0..180, mirror for positive X
  logic signed [ACC_W-1:0] acc_cl;
  logic [H_W-1:0]          acc_u;
  logic                    va;
  logic [H_W-1:0]          ha;
  chfm_side_t              side_a;

  always_comb begin
    if (acc_c[ACC_W-1]) begin
      acc_cl = '0;
    end else if (acc_c > DEG180) begin
      acc_cl = DEG180;
    end else begin
      acc_cl = acc_c;
    end
  end
  assign acc_u = acc_cl[H_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ha     <= side_c.x_pos ? DEG360 - acc_u : acc_u;
      side_a <= side_c;
    end
  end

  // stage B: round half up, 360 wraps to 0
  logic [H_W:0]     h_rnd;
  logic [ANG_W-1:0] north_rnd;
  logic             vb;
  logic [ANG_W-1:0] north_b;
  chfm_side_t       side_b;

  assign h_rnd     = (H_W+1)'(ha) + RND_HALF;
  assign north_rnd = ANG_W'(h_rnd >> RND_SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      north_b <= (north_rnd >= FULL_A) ? north_rnd - FULL_A : north_rnd;
      side_b  <= side_a;
    end
  end

  // output register: add axis offset and wrap; a zero field clears both headings
  logic [ANG_W-1:0] axis_sum;
  logic [ANG_W-1:0] axis_w;

  assign axis_sum = north_b + off_red;
  assign axis_w   = (axis_sum >= FULL_A) ? axis_sum - FULL_A : axis_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_b.zero) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {HEAD_W'(axis_w), HEAD_W'(north_b)};
      end
      m_tuser <= side_b.zero;
    end
  end

  // ---------------- checks ----------------
  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("zero field word carries a nonzero heading");

  a_north_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (FULL <= 65536) |-> ({16'd0, m_tdata[HEAD_W-1:0]} < 32'(FULL)))
    else $error("north heading at or above full circle");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (FULL <= 65536) |-> ({16'd0, m_tdata[2*HEAD_W-1:HEAD_W]} < 32'(FULL)))
    else $error("axis heading at or above full circle");

  a_off_reduced: assert property (@(posedge clk) disable iff (rst)
    off_red < FULL_A)
    else $error("reduced axis offset not below full circle");

endmodule
